[hdl/arxks_pkg.sv]
package arxks_pkg;

    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 8;
    localparam int STEP_W      = $clog2(NUM_WORDS);
    localparam int ROT_AMT     = 9;
    localparam int SETUP_RNDS_A = 2;
    localparam int SETUP_RNDS_B = 62;
    localparam int RND_CNT_W   = $clog2(SETUP_RNDS_B + 1);
    localparam int FOLD_STEPS  = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int COUNT_W     = 4;
    localparam int NUM_BYTES   = WORD_W / 8;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_0   = 3'd0,
        REG_KEY_1   = 3'd1,
        REG_KEY_2   = 3'd2,
        REG_KEY_3   = 3'd3,
        REG_NONCE_0 = 3'd4,
        REG_NONCE_1 = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_ROUND,
        ST_FOLD
    } state_t;

    function automatic logic [WORD_W-1:0] rotl9(input logic [WORD_W-1:0] v);
        return (v << ROT_AMT) | (v >> (WORD_W - ROT_AMT));
    endfunction

endpackage

[hdl/arx_stream_cipher_keystream_top.sv]
// Channel   Handshake            Payload
// --------  -------------------  ------------------------------------------
// input     s_valid / s_ready    s_kind, s_data_in, s_byte_count
// result    m_valid / m_ready    m_data_out, m_valid_bytes
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A start item keeps the block busy through a load step, two passes that sum the words
// into the accumulator, and 64 rounds (one word update per cycle through the shared ARX
// unit). A data item runs one round and a keystream fold. s_ready is high only when idle,
// so a new item is taken only once the last one is done. Reset (aresetn low, synchronous)
// clears the configuration registers, round words and accumulator. A waiting result holds
// the last fold step; idle still takes items.
module arx_stream_cipher_keystream_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_kind,
    input  logic [arxks_pkg::WORD_W-1:0]       s_data_in,
    input  logic [arxks_pkg::COUNT_W-1:0]      s_byte_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [arxks_pkg::WORD_W-1:0]       m_data_out,
    output logic [arxks_pkg::COUNT_W-1:0]      m_valid_bytes,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [arxks_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arxks_pkg::WORD_W-1:0]       cfg_data
);
    import arxks_pkg::*;

    // Configuration registers; they are copied into the round words only by
    // the load step of a start item.
    logic [WORD_W-1:0] key_reg [4];
    logic [WORD_W-1:0] nonce_reg [2];

    // The round words live in a circular shift line. The word being updated
    // always sits at position 0 and its successor at position 1, so the
    // shared unit reads fixed taps only. After eight shifts the words are
    // back in their natural order.
    logic [WORD_W-1:0] q_reg [NUM_WORDS];
    logic [WORD_W-1:0] q_next [NUM_WORDS];
    logic [WORD_W-1:0] acc_reg, acc_next;
    // Raw update of word 0 in the current round; word 7 needs it before the
    // pre-round value of word 0 has been added back.
    logic [WORD_W-1:0] w0_reg, w0_next;
    logic [WORD_W-1:0] ks_reg, ks_next;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [RND_CNT_W-1:0]   rounds_reg, rounds_next;
    logic                   second_pass_reg, second_pass_next;

    logic                   kind_reg, kind_next;
    logic [WORD_W-1:0]      data_reg, data_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    logic                   m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]      m_data_reg, m_data_next;
    logic [COUNT_W-1:0]     m_bytes_reg, m_bytes_next;

    logic [WORD_W-1:0] arx_old, arx_succ, arx_w;
    logic [WORD_W-1:0] fold_base, fold_add, fold_xor, fold_sum;
    logic [WORD_W-1:0] byte_mask;
    logic              in_accept;
    logic              out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_data_out    = m_data_reg;
    assign m_valid_bytes = m_bytes_reg;

    // Shared ARX unit: one word update per cycle.
    assign arx_old  = q_reg[0];
    assign arx_succ = (step_reg == STEP_W'(NUM_WORDS - 1)) ? w0_reg : q_reg[1];
    assign arx_w    = rotl9((arx_old + arx_succ + acc_reg) ^ arx_old);

    // Keystream fold, one add and one XOR per cycle.
    always_comb begin
        fold_base = ks_reg;
        fold_add  = q_reg[7];
        fold_xor  = '0;
        case (step_reg)
            STEP_W'(0): begin
                fold_base = q_reg[0];
                fold_add  = q_reg[6];
                fold_xor  = q_reg[1];
            end
            STEP_W'(1): begin
                fold_add = q_reg[5];
                fold_xor = q_reg[2];
            end
            STEP_W'(2): begin
                fold_add = q_reg[4];
                fold_xor = q_reg[3];
            end
            default: begin
                fold_add = q_reg[7];
                fold_xor = '0;
            end
        endcase
        fold_sum = (fold_base + fold_add) ^ fold_xor;
    end

    always_comb begin
        for (int b = 0; b < NUM_BYTES; b++) begin
            byte_mask[8*b +: 8] = (COUNT_W'(b) < count_reg) ? BYTE_ONES : 8'h00;
        end
    end

    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        rounds_next      = rounds_reg;
        second_pass_next = second_pass_reg;
        q_next           = q_reg;
        acc_next         = acc_reg;
        w0_next          = w0_reg;
        ks_next          = ks_reg;
        kind_next        = kind_reg;
        data_next        = data_reg;
        count_next       = count_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_bytes_next     = m_bytes_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    kind_next  = s_kind;
                    data_next  = s_data_in;
                    // Counts above eight saturate to a full block.
                    count_next = (s_byte_count > COUNT_W'(NUM_BYTES)) ?
                                 COUNT_W'(NUM_BYTES) : s_byte_count;
                    step_next  = '0;
                    if (s_kind == KIND_START) begin
                        state_next = ST_LOAD;
                    end else begin
                        rounds_next = RND_CNT_W'(1);
                        state_next  = ST_ROUND;
                    end
                end
            end
            ST_LOAD: begin
                q_next[0] = key_reg[0] ^ nonce_reg[0];
                q_next[1] = key_reg[1] ^ nonce_reg[1];
                q_next[2] = key_reg[2];
                q_next[3] = key_reg[3];
                for (int k = 4; k < NUM_WORDS; k++) begin
                    q_next[k] = '0;
                end
                acc_next         = '0;
                second_pass_next = 1'b0;
                step_next        = '0;
                state_next       = ST_SUM;
            end
            ST_SUM: begin
                acc_next = acc_reg + q_reg[0];
                for (int k = 0; k < NUM_WORDS - 1; k++) begin
                    q_next[k] = q_reg[k+1];
                end
                q_next[NUM_WORDS-1] = q_reg[0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_WORDS - 1)) begin
                    rounds_next = second_pass_reg ? RND_CNT_W'(SETUP_RNDS_B) :
                                                    RND_CNT_W'(SETUP_RNDS_A);
                    state_next  = ST_ROUND;
                end
            end
            ST_ROUND: begin
                acc_next = acc_reg + arx_w;
                if (step_reg == '0) begin
                    w0_next = arx_w;
                end
                for (int k = 0; k < NUM_WORDS - 1; k++) begin
                    q_next[k] = q_reg[k+1];
                end
                // The word re-enters the line with its pre-round value added.
                q_next[NUM_WORDS-1] = arx_w + arx_old;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_WORDS - 1)) begin
                    rounds_next = rounds_reg - RND_CNT_W'(1);
                    if (rounds_reg == RND_CNT_W'(1)) begin
                        if (kind_reg == KIND_DATA) begin
                            state_next = ST_FOLD;
                        end else if (!second_pass_reg) begin
                            second_pass_next = 1'b1;
                            state_next       = ST_SUM;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_FOLD: begin
                if (step_reg == STEP_W'(FOLD_STEPS - 1)) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = data_reg ^ (fold_sum & byte_mask);
                        m_bytes_next = count_reg;
                        step_next    = '0;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    ks_next   = fold_sum;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            rounds_reg      <= '0;
            second_pass_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            acc_reg         <= '0;
            for (int k = 0; k < NUM_WORDS; k++) begin
                q_reg[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                key_reg[k] <= '0;
            end
            nonce_reg[0] <= '0;
            nonce_reg[1] <= '0;
        end else begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            rounds_reg      <= rounds_next;
            second_pass_reg <= second_pass_next;
            m_valid_reg     <= m_valid_next;
            acc_reg         <= acc_next;
            q_reg           <= q_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_0:   key_reg[0]   <= cfg_data;
                    REG_KEY_1:   key_reg[1]   <= cfg_data;
                    REG_KEY_2:   key_reg[2]   <= cfg_data;
                    REG_KEY_3:   key_reg[3]   <= cfg_data;
                    REG_NONCE_0: nonce_reg[0] <= cfg_data;
                    REG_NONCE_1: nonce_reg[1] <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        w0_reg      <= w0_next;
        ks_reg      <= ks_next;
        kind_reg    <= kind_next;
        data_reg    <= data_next;
        count_reg   <= count_next;
        m_data_reg  <= m_data_next;
        m_bytes_reg <= m_bytes_next;
    end

    // A busy sequencer never offers to take an item.
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input ready while the sequencer is busy");

    // A start item never yields a result right after it is taken.
    a_start_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_kind == KIND_START) |=> !$rose(m_valid))
        else $error("result raised after a start item");

    // Rounds are only run while some remain.
    a_round_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (rounds_reg != '0))
        else $error("round state with no rounds left");

    // The reported byte count is saturated.
    a_bytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_valid_bytes <= COUNT_W'(NUM_BYTES)))
        else $error("valid byte count above a full block");

endmodule
